>>> hdl/mff_pkg.sv
// Shared types and constants for the multichannel frame FIFO.
// No dependencies; imported by every module in the hdl folder.
package mff_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int NUM_LANES  = 8;
    localparam int OP_W       = 3;
    localparam int CAP_W      = 9;
    localparam int CHAN_W     = 4;
    localparam int FILL_W     = 9;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_W      = 9;

    // Stream payload widths, padded to whole bytes
    localparam int IN_TDATA_W  = 264;
    localparam int OUT_TDATA_W = 336;

    // Operation codes
    localparam logic [OP_W-1:0] OP_WRITE      = 3'd0;
    localparam logic [OP_W-1:0] OP_READ       = 3'd1;
    localparam logic [OP_W-1:0] OP_DISCARD    = 3'd2;
    localparam logic [OP_W-1:0] OP_PROD_BEAT  = 3'd3;
    localparam logic [OP_W-1:0] OP_CONS_BEAT  = 3'd4;
    localparam logic [OP_W-1:0] OP_PROD_QUERY = 3'd5;
    localparam logic [OP_W-1:0] OP_CONS_QUERY = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 1'd1;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 9'd256;
    localparam logic [CHAN_W-1:0] CHAN_RESET = 4'd2;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // Per-request status from the control unit
    typedef struct packed {
        logic              accepted;
        logic [FILL_W-1:0] fill;
        logic [CNT_W-1:0]  drop;
        logic [CNT_W-1:0]  beat;
    } ctrl_result_t;

endpackage

>>> hdl/multichannel_frame_fifo.sv
// Multichannel frame FIFO, top level: control unit, one storage lane per channel, merge stage.
// Throughput: one request per cycle unless m_tready stalls the output, as set by the one write
// and one read port of each lane memory. Results go through stage 1, then the output register.
// Reset (rst_n, async, active low) empties the FIFO, clears drop and beat counters and
// restores capacity 256 and channel count 2; frame storage is not cleared.
// Depends on mff_pkg, mff_ctrl, mff_lane.
module multichannel_frame_fifo #(
    parameter int MAX_FRAMES   = 256,
    parameter int MAX_CHANNELS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [mff_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mff_pkg::CFG_W-1:0]         cfg_data,
    // Request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata from bit 0: operation[2:0], in_sample_0 .. in_sample_7 (32 each), zero pad
    input  logic [mff_pkg::IN_TDATA_W-1:0]    s_tdata,
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata from bit 0: accepted, out_sample_0 .. out_sample_7 (32 each),
    // fill_frames[8:0], dropped_total[31:0], beat_count[31:0], zero pad
    output logic [mff_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import mff_pkg::*;

    localparam int IDX_W = $clog2(MAX_FRAMES);

    localparam int SAMPLE_LSB = OP_W;
    localparam int OUT_SMP    = 1;
    localparam int OUT_FILL   = OUT_SMP + NUM_LANES * SAMPLE_W;
    localparam int OUT_DROP   = OUT_FILL + FILL_W;
    localparam int OUT_BEAT   = OUT_DROP + CNT_W;
    localparam int OUT_USED   = OUT_BEAT + CNT_W;

    // Control unit interface
    logic                    accept;
    logic                    wr_en;
    logic                    rd_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [IDX_W-1:0]        rd_addr;
    logic [MAX_CHANNELS-1:0] lane_en;
    ctrl_result_t            result;

    // Stage 1: status of the request whose lane reads are in flight
    logic                    s1_valid_reg, s1_valid_next;
    ctrl_result_t            s1_result_reg;
    logic [MAX_CHANNELS-1:0] s1_mask_reg;
    logic                    s1_go;

    // Output register
    logic                    m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0]  m_data_reg;

    sample_t                 rd_data [MAX_CHANNELS];
    sample_t                 merged  [NUM_LANES];
    logic [OUT_TDATA_W-1:0]  packed_result;

    // Stage 1 advances whenever the output register is free or being drained
    assign s1_go    = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_go;
    assign accept   = s_tvalid && s_tready;

    mff_ctrl #(
        .MAX_FRAMES   (MAX_FRAMES),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item_go   (accept),
        .op        (s_tdata[OP_W-1:0]),
        .wr_en     (wr_en),
        .rd_en     (rd_en),
        .wr_addr   (wr_addr),
        .rd_addr   (rd_addr),
        .lane_en   (lane_en),
        .result    (result)
    );

    // One storage lane per channel; lanes above the channel count are not written
    for (genvar g = 0; g < MAX_CHANNELS; g++)
    begin : g_lane
        mff_lane #(
            .MAX_FRAMES (MAX_FRAMES)
        ) u_lane (
            .clk     (clk),
            .wr_en   (wr_en && lane_en[g]),
            .wr_addr (wr_addr),
            .wr_data (s_tdata[SAMPLE_LSB + g*SAMPLE_W +: SAMPLE_W]),
            .rd_en   (rd_en),
            .rd_addr (rd_addr),
            .rd_data (rd_data[g])
        );
    end

    // Merge: zero lanes that were not read or lie above the channel count
    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_merge
        if (g < MAX_CHANNELS)
        begin : g_live
            assign merged[g] = s1_mask_reg[g] ? rd_data[g] : '0;
        end
        else
        begin : g_absent
            assign merged[g] = '0;
        end
    end

    always_comb
    begin
        packed_result = '0;
        packed_result[0] = s1_result_reg.accepted;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            packed_result[OUT_SMP + i*SAMPLE_W +: SAMPLE_W] = merged[i];
        end
        packed_result[OUT_FILL +: FILL_W] = s1_result_reg.fill;
        packed_result[OUT_DROP +: CNT_W]  = s1_result_reg.drop;
        packed_result[OUT_BEAT +: CNT_W]  = s1_result_reg.beat;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;

        m_valid_next = m_valid_reg;
        if (s1_valid_reg && s1_go)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers: hold status alongside the lane read data
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_result_reg <= result;
            s1_mask_reg   <= lane_en & {MAX_CHANNELS{rd_en}};
        end
        if (s1_valid_reg && s1_go)
        begin
            m_data_reg <= packed_result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_data_reg[OUT_TDATA_W-1:OUT_USED], m_data_reg[OUT_USED-1:0]};

endmodule

>>> hdl/mff_lane.sv
// One channel lane of frame storage: a simple dual-port memory with registered read.
// Depends on mff_pkg.
module mff_lane #(
    parameter int MAX_FRAMES = 256,
    localparam int IDX_W = $clog2(MAX_FRAMES)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  mff_pkg::sample_t  wr_data,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output mff_pkg::sample_t  rd_data
);
    import mff_pkg::*;

    sample_t mem [MAX_FRAMES];
    sample_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/mff_ctrl.sv
// Control unit: configuration registers, ring pointers, fill level, drop and beat counters.
// Depends on mff_pkg.
module mff_ctrl #(
    parameter int MAX_FRAMES   = 256,
    parameter int MAX_CHANNELS = 8,
    localparam int IDX_W = $clog2(MAX_FRAMES)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mff_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mff_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            item_go,
    input  logic [mff_pkg::OP_W-1:0]        op,
    output logic                            wr_en,
    output logic                            rd_en,
    output logic [IDX_W-1:0]                wr_addr,
    output logic [IDX_W-1:0]                rd_addr,
    output logic [MAX_CHANNELS-1:0]         lane_en,
    output mff_pkg::ctrl_result_t           result
);
    import mff_pkg::*;

    // Compare width covers both the capacity register and the pointer range
    localparam int CW = (IDX_W + 1 > CAP_W) ? IDX_W + 1 : CAP_W;

    logic [CAP_W-1:0]  cap_reg,    cap_next;
    logic [CHAN_W-1:0] chan_reg,   chan_next;
    logic [IDX_W-1:0]  wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [FILL_W-1:0] fill_reg,   fill_next;
    logic [CNT_W-1:0]  drop_reg,   drop_next;
    logic [CNT_W-1:0]  prod_reg,   prod_next;
    logic [CNT_W-1:0]  cons_reg,   cons_next;

    logic [CW-1:0]     eff_cap;
    logic [CHAN_W-1:0] eff_chan;
    logic [CW-1:0]     wr_inc;
    logic [CW-1:0]     rd_inc;
    logic              can_write;
    logic              can_read;

    always_comb
    begin
        if (cap_reg == '0)
            eff_cap = CW'(1);
        else if (CW'(cap_reg) > CW'(MAX_FRAMES))
            eff_cap = CW'(MAX_FRAMES);
        else
            eff_cap = CW'(cap_reg);

        if (chan_reg == '0)
            eff_chan = CHAN_W'(1);
        else if (chan_reg > CHAN_W'(MAX_CHANNELS))
            eff_chan = CHAN_W'(MAX_CHANNELS);
        else
            eff_chan = chan_reg;
    end

    always_comb
    begin
        for (int i = 0; i < MAX_CHANNELS; i++)
        begin
            lane_en[i] = CHAN_W'(i) < eff_chan;
        end
    end

    assign can_write = CW'(fill_reg) < eff_cap;
    assign can_read  = fill_reg != '0;
    assign wr_inc    = CW'(wr_idx_reg) + CW'(1);
    assign rd_inc    = CW'(rd_idx_reg) + CW'(1);

    assign wr_en   = item_go && !cfg_we && (op == OP_WRITE) && can_write;
    assign rd_en   = item_go && !cfg_we && (op == OP_READ) && can_read;
    assign wr_addr = wr_idx_reg;
    assign rd_addr = rd_idx_reg;

    always_comb
    begin
        cap_next        = cap_reg;
        chan_next       = chan_reg;
        wr_idx_next     = wr_idx_reg;
        rd_idx_next     = rd_idx_reg;
        fill_next       = fill_reg;
        drop_next       = drop_reg;
        prod_next       = prod_reg;
        cons_next       = cons_reg;
        result.accepted = 1'b0;
        result.beat     = '0;

        if (cfg_we)
        begin
            // Any register write empties the FIFO
            case (cfg_index)
                REG_CAPACITY: cap_next  = cfg_data[CAP_W-1:0];
                REG_CHANNELS: chan_next = cfg_data[CHAN_W-1:0];
                default:      cap_next  = cap_reg;
            endcase
            wr_idx_next = '0;
            rd_idx_next = '0;
            fill_next   = '0;
        end
        else if (item_go)
        begin
            case (op)
                OP_WRITE:
                begin
                    if (can_write)
                    begin
                        wr_idx_next     = (wr_inc >= eff_cap) ? '0 : wr_inc[IDX_W-1:0];
                        fill_next       = fill_reg + FILL_W'(1);
                        result.accepted = 1'b1;
                    end
                    else if (drop_reg != '1)
                    begin
                        drop_next = drop_reg + CNT_W'(1);
                    end
                end
                OP_READ:
                begin
                    if (can_read)
                    begin
                        rd_idx_next     = (rd_inc >= eff_cap) ? '0 : rd_inc[IDX_W-1:0];
                        fill_next       = fill_reg - FILL_W'(1);
                        result.accepted = 1'b1;
                    end
                end
                OP_DISCARD:
                begin
                    rd_idx_next = wr_idx_reg;
                    fill_next   = '0;
                end
                OP_PROD_BEAT:
                begin
                    prod_next   = prod_reg + CNT_W'(1);
                    result.beat = prod_next;
                end
                OP_CONS_BEAT:
                begin
                    cons_next   = cons_reg + CNT_W'(1);
                    result.beat = cons_next;
                end
                OP_PROD_QUERY: result.beat = prod_reg;
                OP_CONS_QUERY: result.beat = cons_reg;
                default:       result.beat = '0;
            endcase
        end

        result.fill = fill_next;
        result.drop = drop_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= CAP_RESET;
            chan_reg   <= CHAN_RESET;
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            fill_reg   <= '0;
            drop_reg   <= '0;
            prod_reg   <= '0;
            cons_reg   <= '0;
        end
        else
        begin
            cap_reg    <= cap_next;
            chan_reg   <= chan_next;
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            fill_reg   <= fill_next;
            drop_reg   <= drop_next;
            prod_reg   <= prod_next;
            cons_reg   <= cons_next;
        end
    end

endmodule
